### hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/bmhq_pkg.sv
// Package for the binary min-heap queue: port widths, opcodes, status codes
// and the controller state type. No dependencies.
package bmhq_pkg;

  localparam int OPCODE_W     = 2;
  localparam int KEY_PORT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 7;

  localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

### hdl/bmhq_req_if.sv
// Request channel of the heap queue: valid/ready plus opcode and key.
// Depends on bmhq_pkg.
interface bmhq_req_if;
  import bmhq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [KEY_PORT_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

### hdl/bmhq_rsp_if.sv
// Result channel of the heap queue: valid/ready plus status and heap summary.
// Depends on bmhq_pkg.
interface bmhq_rsp_if;
  import bmhq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [KEY_PORT_W-1:0]   top_key;
  logic                    top_valid;
  logic [COUNT_PORT_W-1:0] entry_count;

  modport source (output valid, output status, output top_key, output top_valid,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input top_key, input top_valid,
                  input entry_count, output ready);
endinterface

### hdl/bmhq_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/binary_min_heap_queue.sv
// Binary min-heap priority queue of unsigned keys, one request at a time.
// A request is push (0), pop (1) or clear (2); opcode 3 does nothing. Each
// request returns one result: status (done, push rejected when full, pop
// ignored when empty), the smallest key (zero when empty), a nonempty flag
// and the entry count. Keys are kept in one RAM (1-based heap positions at
// address position-1) and the root is mirrored in a register, so the result
// needs no extra read. Timing is set by the single RAM read port, one
// registered read per cycle. Clear, no-op, rejected requests, a push to an
// empty heap and a pop of the last entry go straight to the result; a push
// first climbs from the new leaf towards the root, and a pop first moves the
// last key to the root and sinks it level by level. The result appears as
// the queue returns to idle, ready for the next request. A new request is
// taken while the previous result still waits to be collected.
// The key store needs no clearing pass after reset: values read from
// positions beyond the fill count are never used.
// Depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and bmhq_ram.
module binary_min_heap_queue #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  bmhq_req_if.sink   req,
  bmhq_rsp_if.source rsp
);
  import bmhq_pkg::*;

  // stored key width: the request key port is fixed, KEY_WIDTH masks it
  localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [CW-1:0] count, count_next;   // fill count
  logic [CW-1:0] pos, pos_next;       // current heap position, 1-based
  logic [KW-1:0] hold, hold_next;     // key being placed (pushed or moved)
  logic [KW-1:0] left_key, left_next; // left child during a sift down
  logic [KW-1:0] root;                // copy of position 1
  logic [STATUS_W-1:0] status, status_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [KW-1:0] ram_wdata, ram_rdata;

  logic          out_free;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] pos_half;
  logic [CW:0]   dbl;       // 2*pos, left child position
  logic          pick_right;
  logic [KW-1:0] kid_key;
  logic [CW-1:0] kid_pos;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] p);
    logic [CW-1:0] a;
    a = p - CW'(1);
    return a[AW-1:0];
  endfunction

  bmhq_ram #(
    .WIDTH(KW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free   = !rsp.valid || rsp.ready;
  assign cnt_inc    = count + CW'(1);
  assign pos_half   = pos >> 1;
  assign dbl        = {pos, 1'b0};
  // right child wins only when strictly below the left
  assign pick_right = ram_rdata < left_key;
  assign kid_key    = pick_right ? ram_rdata : left_key;
  assign kid_pos    = pick_right ? (dbl[CW-1:0] + CW'(1)) : dbl[CW-1:0];

  assign req.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.opcode)
            OP_PUSH: begin
              if (count >= CW'(CAPACITY) || count == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_UP;
              end
            end
            OP_POP: begin
              if (count <= CW'(1)) begin
                state_next = S_DONE;
              end else begin
                state_next = S_DN_LAST;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_UP: begin
        // keep climbing while strictly below the parent; a move into the root ends the climb
        if (hold < ram_rdata && pos_half != CW'(1)) begin
          state_next = S_UP;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_LAST: state_next = S_DN_CHK;
      S_DN_CHK: begin
        if (dbl > {1'b0, count}) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        if (dbl < {1'b0, count}) begin
          state_next = S_DN_R;
        end else if (ram_rdata < hold) begin
          state_next = S_DN_CHK;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_R: begin
        if (kid_key < hold) begin
          state_next = S_DN_CHK;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    count_next  = count;
    pos_next    = pos;
    hold_next   = hold;
    left_next   = left_key;
    status_next = status;
    ram_we      = 1'b0;
    ram_waddr   = addr_of(pos);
    ram_wdata   = hold;
    ram_raddr   = addr_of(pos_half);
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          status_next = ST_DONE;
          hold_next   = req.key[KW-1:0];
          case (req.opcode)
            OP_PUSH: begin
              if (count >= CW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                count_next = cnt_inc;
                pos_next   = cnt_inc;
                ram_raddr  = addr_of(cnt_inc >> 1);
                if (count == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = addr_of(CW'(1));
                  ram_wdata = req.key[KW-1:0];
                end
              end
            end
            OP_POP: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                pos_next   = CW'(1);
                ram_raddr  = addr_of(count);   // last key
              end
            end
            OP_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      S_UP: begin
        if (hold < ram_rdata) begin
          // parent moves down into the hole
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_next  = pos_half;
          ram_raddr = addr_of(pos_half >> 1);
        end
      end
      S_DN_LAST: hold_next = ram_rdata;
      S_DN_CHK:  ram_raddr = addr_of(dbl[CW-1:0]);
      S_DN_L: begin
        left_next = ram_rdata;
        ram_raddr = addr_of(dbl[CW-1:0] + CW'(1));
        if (dbl == {1'b0, count} && ram_rdata < hold) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_next  = dbl[CW-1:0];
        end
      end
      S_DN_R: begin
        if (kid_key < hold) begin
          ram_we    = 1'b1;
          ram_wdata = kid_key;
          pos_next  = kid_pos;
        end
      end
      S_PLACE: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    hold     <= hold_next;
    left_key <= left_next;
    status   <= status_next;
    if (ram_we && ram_waddr == '0) begin
      root <= ram_wdata;
    end
    if (state == S_DONE && out_free) begin
      rsp.status      <= status;
      rsp.top_valid   <= (count != '0);
      rsp.top_key     <= (count != '0) ? KEY_PORT_W'(root) : '0;
      rsp.entry_count <= COUNT_PORT_W'(count);
    end
  end

endmodule

### hdl/bmhq_checker.sv
// Port-level checker for the heap queue and its bind to the top level.
// Depends on bmhq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmhq_checker #(
  parameter int CAPACITY = 64
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [bmhq_pkg::STATUS_W-1:0]     rsp_status,
  input logic [bmhq_pkg::KEY_PORT_W-1:0]   rsp_top_key,
  input logic                              rsp_top_valid,
  input logic [bmhq_pkg::COUNT_PORT_W-1:0] rsp_entry_count
);
  import bmhq_pkg::*;

  localparam logic [COUNT_PORT_W-1:0] FULL_COUNT = COUNT_PORT_W'(CAPACITY);
  localparam int PAYLOAD_W = STATUS_W + KEY_PORT_W + 1 + COUNT_PORT_W;

  logic                 stalled;
  logic [PAYLOAD_W-1:0] payload;
  logic                 shows_full;
  logic                 shows_empty;

  assign stalled     = rsp_valid && !rsp_ready;
  assign payload     = {rsp_status, rsp_top_key, rsp_top_valid, rsp_entry_count};
  assign shows_full  = rsp_top_valid && rsp_entry_count == FULL_COUNT;
  assign shows_empty = !rsp_top_valid && rsp_entry_count == '0;

  // a stalled result stays up with its payload unchanged
  `ASSERT_NEXT(a_stall_hold, clk, rst, stalled, rsp_valid && $stable(payload))
  // empty heap reports no top key
  `ASSERT_IMPLIES(a_empty_top, clk, rst, rsp_valid && !rsp_top_valid, rsp_top_key == '0)
  // rejected push only when at capacity
  `ASSERT_IMPLIES(a_full, clk, rst, rsp_valid && rsp_status == ST_FULL, shows_full)
  // ignored pop only when empty
  `ASSERT_IMPLIES(a_empty_pop, clk, rst, rsp_valid && rsp_status == ST_EMPTY, shows_empty)

endmodule

bind binary_min_heap_queue bmhq_checker #(
  .CAPACITY(CAPACITY)
) u_bmhq_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_top_key    (rsp.top_key),
  .rsp_top_valid  (rsp.top_valid),
  .rsp_entry_count(rsp.entry_count)
);
